// File: rtl/nts_pkg.sv
// Package for the nearest timestamp search: codes, states and control structs.
package nts_pkg;

  localparam int TV_W   = 48;  // stored and query timestamp width
  localparam int DIFF_W = 49;  // reported difference width
  localparam int IDX_W  = 10;  // reported index width
  localparam int ADJ_W  = TV_W + 1;  // timestamp plus offset
  localparam int FULL_W = TV_W + 2;  // exact query minus adjusted timestamp

  typedef enum logic [1:0] {
    ACT_LOAD  = 2'd0,
    ACT_SEEK  = 2'd1,
    ACT_CLEAR = 2'd2,
    ACT_NONE  = 2'd3
  } nts_action_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN
  } nts_state_t;

  typedef struct packed {
    logic load;        // write item into table at fill position
    logic clear;       // empty the table
    logic seek_init;   // latch query, rewind scan
    logic issue;       // read next entry into the compare pipe
    logic emit;        // present best match
    logic emit_empty;  // present empty-table result
  } nts_cmd_t;

  typedef struct packed {
    logic count_zero;
    logic full;
    logic last_addr;   // scan address is the last loaded entry
    logic pipe_idle;   // no entry in flight in the compare pipe
  } nts_stat_t;

endpackage

// File: rtl/nts_ctrl.sv
// Controller state machine for the nearest timestamp search.
module nts_ctrl
  import nts_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  logic [1:0] action,
  input  nts_stat_t stat,
  output logic      busy,
  output nts_cmd_t  cmd
);

  nts_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (start && (nts_action_t'(action) == ACT_SEEK) && !stat.count_zero) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (stat.last_addr) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (stat.pipe_idle) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = (state_r != ST_IDLE);
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          case (nts_action_t'(action))
            ACT_LOAD:  cmd.load  = !stat.full;
            ACT_CLEAR: cmd.clear = 1'b1;
            ACT_SEEK: begin
              cmd.emit_empty = stat.count_zero;
              cmd.seek_init  = !stat.count_zero;
            end
            default: ;
          endcase
        end
      end
      ST_SCAN:  cmd.issue = 1'b1;
      ST_DRAIN: cmd.emit  = stat.pipe_idle;
      default: ;
    endcase
  end

endmodule

// File: rtl/nts_dp.sv
// Datapath: timestamp table, fill count, compare pipe and result registers.
module nts_dp
  import nts_pkg::*;
#(
  parameter int TABLE_DEPTH = 1024
) (
  input  logic              clk,
  input  logic              rst_n,
  input  nts_cmd_t          cmd,
  input  logic [TV_W-1:0]   time_value,
  input  logic              cfg_wr_en,
  input  logic [TV_W-1:0]   cfg_time_offset,
  output nts_stat_t         stat,
  output logic              out_valid,
  output logic [IDX_W-1:0]  out_nearest_index,
  output logic [DIFF_W-1:0] out_time_diff,
  output logic              out_empty_error
);

  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);
  localparam logic [CW-1:0] ONE_C   = CW'(1);

  logic [TV_W-1:0] mem [TABLE_DEPTH];

  logic [CW-1:0]   count_r;
  logic [TV_W-1:0] offset_r;
  logic [TV_W-1:0] query_r;
  logic [AW-1:0]   addr_r;

  // compare pipe: read, adjust, difference
  logic              a_vld_r, b_vld_r, c_vld_r;
  logic [AW-1:0]     a_idx_r, b_idx_r, c_idx_r;
  logic [TV_W-1:0]   rd_data_r;
  logic [ADJ_W-1:0]  adj_r;
  logic [FULL_W-1:0] diff_r, mag_r;

  // running best
  logic              have_r;
  logic [AW-1:0]     best_idx_r;
  logic [FULL_W-1:0] best_diff_r, best_mag_r;

  logic [ADJ_W-1:0]  adj_nxt;
  logic [FULL_W-1:0] dpos, dneg;
  logic [DIFF_W-1:0] sat_diff;
  logic [IDX_W+AW-1:0] idx_ext;
  logic              take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      offset_r <= '0;
    end else begin
      if (cfg_wr_en) begin
        offset_r <= cfg_time_offset;
      end
      if (cmd.clear) begin
        count_r <= '0;
      end else if (cmd.load) begin
        count_r <= count_r + ONE_C;
      end
    end
  end

  // table: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mem[count_r[AW-1:0]] <= time_value;
    end
    if (cmd.issue) begin
      rd_data_r <= mem[addr_r];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.seek_init) begin
      query_r <= time_value;
      addr_r  <= '0;
    end else if (cmd.issue) begin
      addr_r <= addr_r + AW'(1);
    end
  end

  assign adj_nxt = {rd_data_r[TV_W-1], rd_data_r} + {offset_r[TV_W-1], offset_r};
  assign dpos = {{2{query_r[TV_W-1]}}, query_r} - {adj_r[ADJ_W-1], adj_r};
  assign dneg = {adj_r[ADJ_W-1], adj_r} - {{2{query_r[TV_W-1]}}, query_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
      b_vld_r <= 1'b0;
      c_vld_r <= 1'b0;
    end else begin
      a_vld_r <= cmd.issue;
      b_vld_r <= a_vld_r;
      c_vld_r <= b_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    a_idx_r <= addr_r;
    b_idx_r <= a_idx_r;
    c_idx_r <= b_idx_r;
    adj_r   <= adj_nxt;
    diff_r  <= dpos;
    mag_r   <= dpos[FULL_W-1] ? dneg : dpos;
  end

  // strict less-than keeps the earliest entry on a tie
  assign take = c_vld_r && (!have_r || (mag_r < best_mag_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_r <= 1'b0;
    end else if (cmd.seek_init) begin
      have_r <= 1'b0;
    end else if (take) begin
      have_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      best_idx_r  <= c_idx_r;
      best_diff_r <= diff_r;
      best_mag_r  <= mag_r;
    end
  end

  // saturate the exact difference to the reported range
  always_comb begin
    if (best_diff_r[FULL_W-1] != best_diff_r[FULL_W-2]) begin
      sat_diff = best_diff_r[FULL_W-1] ? {1'b1, {(DIFF_W-1){1'b0}}}
                                       : {1'b0, {(DIFF_W-1){1'b1}}};
    end else begin
      sat_diff = best_diff_r[DIFF_W-1:0];
    end
  end

  assign idx_ext = {{IDX_W{1'b0}}, best_idx_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= cmd.emit || cmd.emit_empty;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_empty) begin
      out_nearest_index <= '0;
      out_time_diff     <= '0;
      out_empty_error   <= 1'b1;
    end else if (cmd.emit) begin
      out_nearest_index <= idx_ext[IDX_W-1:0];
      out_time_diff     <= sat_diff;
      out_empty_error   <= 1'b0;
    end
  end

  assign stat.count_zero = (count_r == '0);
  assign stat.full       = (count_r == DEPTH_C);
  assign stat.last_addr  = (CW'(addr_r) == (count_r - ONE_C));
  assign stat.pipe_idle  = !a_vld_r && !b_vld_r && !c_vld_r;

endmodule

// File: rtl/nearest_timestamp_search.sv
// Top level of the nearest timestamp search: controller plus datapath.
//
//  Channel   Ports                                      Handshake
//  --------  -----------------------------------------  ---------------------------
//  input     in_action, in_time_value                   taken when start && !busy
//  result    out_nearest_index, out_time_diff,          one cycle, out_valid strobe
//            out_empty_error
//  config    cfg_time_offset                            written when cfg_wr_en
//
// Load, clear and unused-code items never raise busy.
// A seek on a non-empty table holds busy while the scan reads one
// table entry per cycle through the single read port, then a three-stage
// compare pipe (read, add offset, subtract) drains. The result strobes in the
// same cycle as busy drops. A seek on an empty table strobes the next cycle.
// rst_n is synchronous: it empties the table and zeroes the offset; no
// clearing pass is needed. The receiver cannot stall, so nothing backs up.
module nearest_timestamp_search
  import nts_pkg::*;
#(
  parameter int TABLE_DEPTH = 1024
) (
  input  logic              clk,
  input  logic              rst_n,
  // input items
  input  logic              start,
  output logic              busy,
  input  logic [1:0]        in_action,
  input  logic [TV_W-1:0]   in_time_value,
  // results
  output logic              out_valid,
  output logic [IDX_W-1:0]  out_nearest_index,
  output logic [DIFF_W-1:0] out_time_diff,
  output logic              out_empty_error,
  // configuration
  input  logic              cfg_wr_en,
  input  logic [TV_W-1:0]   cfg_time_offset
);

  nts_cmd_t  cmd;
  nts_stat_t stat;

  nts_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .action (in_action),
    .stat   (stat),
    .busy   (busy),
    .cmd    (cmd)
  );

  nts_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .time_value        (in_time_value),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_time_offset   (cfg_time_offset),
    .stat              (stat),
    .out_valid         (out_valid),
    .out_nearest_index (out_nearest_index),
    .out_time_diff     (out_time_diff),
    .out_empty_error   (out_empty_error)
  );

`ifndef ASSERT_OFF
  // a result only follows a seek accept or the end of a scan
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($past(busy) || $past(start)))
    else $error("result without a seek");

  // busy only ends by presenting the result
  a_busy_end: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_valid)
    else $error("scan ended without a result");

  // scanning never runs over an empty table
  a_scan_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.issue |-> !stat.count_zero)
    else $error("scan issued on empty table");

  // empty-table result carries zero index and difference
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_empty_error) |-> (out_nearest_index == '0 && out_time_diff == '0))
    else $error("empty result not zeroed");
`endif

endmodule
